/* rtl/ascp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascp_pkg
// Shared constants and types of the ASCII CAN frame parser.
// ----------------------------------------------------------------------------
package ascp_pkg;

   localparam int MAX_PAYLOAD_BYTES = 8;
   localparam int MAX_DIGITS        = 2 * MAX_PAYLOAD_BYTES;
   localparam int DATA_CNT_W        = $clog2(MAX_DIGITS + 2);
   localparam int NIB_IDX_W         = (MAX_DIGITS > 2) ? $clog2(MAX_DIGITS) : 1;

   localparam int CHAR_W     = 8;
   localparam int ID_W       = 12;
   localparam int ID_CNT_W   = 3;
   localparam int BYTE_CNT_W = 4;
   localparam int PAYLOAD_W  = 64;

   localparam logic [ID_CNT_W-1:0] ID_MAX_DIGITS = ID_CNT_W'(3);
   localparam logic [ID_CNT_W-1:0] ID_OVERFLOW   = ID_CNT_W'(4);

   localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;

   localparam logic [ID_W-1:0]       CMD_ID        = 12'h0A0;
   localparam logic [7:0]            CMD_BYTE_RUN  = 8'h66;
   localparam logic [7:0]            CMD_BYTE_ALT  = 8'hFF;
   localparam logic [7:0]            CMD_BYTE_ONE  = 8'h01;
   localparam logic [BYTE_CNT_W-1:0] CMD_BYTES     = 4'd2;

   typedef struct packed {
      logic                  in_payload;
      logic                  bad_frame;
      logic [ID_CNT_W-1:0]   id_cnt;
      logic [ID_W-1:0]       id_val;
      logic [DATA_CNT_W-1:0] data_cnt;
      logic [PAYLOAD_W-1:0]  data_val;
   } frame_snap_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] nibble;
   } hex_digit_type;

endpackage

/* rtl/ascp_hex_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascp_hex_decode
// Maps one ASCII character to a hex nibble and a digit flag.
// ----------------------------------------------------------------------------
module ascp_hex_decode
   import ascp_pkg::*;
(
   input  logic [CHAR_W-1:0] character,
   output hex_digit_type     digit
);

   always_comb begin
      digit.is_hex = 1'b0;
      digit.nibble = 4'd0;
      if (character >= CHAR_0 && character <= CHAR_9) begin
         digit.is_hex = 1'b1;
         digit.nibble = 4'(character - CHAR_0);
      end else if (character >= CHAR_LO_A && character <= CHAR_LO_F) begin
         digit.is_hex = 1'b1;
         digit.nibble = 4'(character - CHAR_LO_A + 8'd10);
      end else if (character >= CHAR_UP_A && character <= CHAR_UP_F) begin
         digit.is_hex = 1'b1;
         digit.nibble = 4'(character - CHAR_UP_A + 8'd10);
      end
   end

endmodule

/* rtl/ascp_frame_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascp_frame_accum
// Frame state: phase, ID and payload digit gathering, cleared after a frame.
// ----------------------------------------------------------------------------
module ascp_frame_accum
   import ascp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [CHAR_W-1:0] character,
   input  logic              last,
   output frame_snap_type    snap
);

   frame_snap_type state_ff;
   hex_digit_type  digit;
   logic [NIB_IDX_W-1:0] lane_sel;

   ascp_hex_decode u_hex (
      .character (character),
      .digit     (digit)
   );

   // high nibble of each byte comes first, so digit k lands in nibble lane k^1
   assign lane_sel = state_ff.data_cnt[NIB_IDX_W-1:0] ^ NIB_IDX_W'(1);

   always_comb begin
      snap = state_ff;
      if (!state_ff.in_payload) begin
         if (character == CHAR_HASH) begin
            snap.in_payload = 1'b1;
         end else if (!digit.is_hex) begin
            snap.bad_frame = 1'b1;
         end else if (state_ff.id_cnt < ID_MAX_DIGITS) begin
            snap.id_val = {state_ff.id_val[ID_W-5:0], digit.nibble};
            snap.id_cnt = state_ff.id_cnt + ID_CNT_W'(1);
         end else begin
            snap.id_cnt    = ID_OVERFLOW;
            snap.bad_frame = 1'b1;
         end
      end else begin
         if (!digit.is_hex) begin
            snap.bad_frame = 1'b1;
         end else if (state_ff.data_cnt < DATA_CNT_W'(MAX_DIGITS)) begin
            for (int j = 0; j < MAX_DIGITS; j++) begin
               if (lane_sel == NIB_IDX_W'(j)) begin
                  snap.data_val[j*4 +: 4] = state_ff.data_val[j*4 +: 4] | digit.nibble;
               end
            end
            snap.data_cnt = state_ff.data_cnt + DATA_CNT_W'(1);
         end else begin
            snap.data_cnt  = DATA_CNT_W'(MAX_DIGITS + 1);
            snap.bad_frame = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (take) begin
         // clear after the last character of a frame
         if (last) begin
            state_ff <= '0;
         end else begin
            state_ff <= snap;
         end
      end
   end

endmodule

/* rtl/ascp_result_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascp_result_reg
// Frame validity and command checks, held in the result register.
// ----------------------------------------------------------------------------
module ascp_result_reg
   import ascp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  frame_snap_type        snap,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_valid_res,
   output logic [ID_W-1:0]       rsp_frame_id,
   output logic [BYTE_CNT_W-1:0] rsp_byte_count,
   output logic [PAYLOAD_W-1:0]  rsp_payload,
   output logic                  rsp_is_start,
   output logic                  rsp_is_stop
);

   logic                  ok;
   logic [BYTE_CNT_W-1:0] nbytes;
   logic [7:0]            b0;
   logic [7:0]            b1;
   logic                  cmd_frame;

   logic                  valid_ff;
   logic                  valid_res_ff;
   logic [ID_W-1:0]       frame_id_ff;
   logic [BYTE_CNT_W-1:0] byte_count_ff;
   logic [PAYLOAD_W-1:0]  payload_ff;
   logic                  is_start_ff;
   logic                  is_stop_ff;

   assign ok = !snap.bad_frame && snap.in_payload
            && snap.id_cnt >= ID_CNT_W'(1) && snap.id_cnt <= ID_MAX_DIGITS
            && snap.data_cnt >= DATA_CNT_W'(2)
            && snap.data_cnt <= DATA_CNT_W'(MAX_DIGITS)
            && !snap.data_cnt[0];

   assign nbytes    = BYTE_CNT_W'(snap.data_cnt >> 1);
   assign b0        = snap.data_val[7:0];
   assign b1        = snap.data_val[15:8];
   assign cmd_frame = ok && snap.id_val == CMD_ID && nbytes == CMD_BYTES;

   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         valid_res_ff  <= ok;
         frame_id_ff   <= ok ? snap.id_val : '0;
         byte_count_ff <= ok ? nbytes : '0;
         payload_ff    <= ok ? snap.data_val : '0;
         is_start_ff   <= cmd_frame && b1 == CMD_BYTE_ONE
                          && (b0 == CMD_BYTE_RUN || b0 == CMD_BYTE_ALT);
         is_stop_ff    <= cmd_frame && b0 == CMD_BYTE_RUN && b1 == CMD_BYTE_ALT;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_valid_res  = valid_res_ff;
   assign rsp_frame_id   = frame_id_ff;
   assign rsp_byte_count = byte_count_ff;
   assign rsp_payload    = payload_ff;
   assign rsp_is_start   = is_start_ff;
   assign rsp_is_stop    = is_stop_ff;

endmodule

/* rtl/ascii_can_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_can_frame_parser
// Parses text CAN frames "III#PP.." one character per item.
// ----------------------------------------------------------------------------
// The block takes one character item per clock cycle while req_stall is low.
// Each item goes into an input register; from there it updates the frame
// state, and on the item flagged last the frame result is written to the
// result register. Only the last character of a frame waits on a full,
// stalled result register; other characters keep flowing while a result
// waits to be taken.
// ----------------------------------------------------------------------------
module ascii_can_frame_parser
   import ascp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_character,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_valid_res,
   output logic [ID_W-1:0]       rsp_frame_id,
   output logic [BYTE_CNT_W-1:0] rsp_byte_count,
   output logic [PAYLOAD_W-1:0]  rsp_payload,
   output logic                  rsp_is_start,
   output logic                  rsp_is_stop
);

   logic              s1_valid_ff;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              s1_last_ff;
   logic              s1_advance;
   logic              out_free;
   frame_snap_type    snap;

   // a last character holds until the result register can take its result
   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_char_ff <= req_character;
         s1_last_ff <= req_last;
      end
   end

   ascp_frame_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .take      (s1_advance),
      .character (s1_char_ff),
      .last      (s1_last_ff),
      .snap      (snap)
   );

   ascp_result_reg u_result (
      .clock          (clock),
      .reset          (reset),
      .load           (s1_advance && s1_last_ff),
      .snap           (snap),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_frame_id   (rsp_frame_id),
      .rsp_byte_count (rsp_byte_count),
      .rsp_payload    (rsp_payload),
      .rsp_is_start   (rsp_is_start),
      .rsp_is_stop    (rsp_is_stop)
   );

endmodule

/* tb/ascii_can_frame_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_can_frame_parser_tb
// Self-checking bench for the text CAN frame parser.
// ----------------------------------------------------------------------------
// Characters of "III#PP.." frames are driven one item per handshake: a few
// directed frames (start and stop commands, bare separator, missing
// separator), then random frames that are mostly well formed with some
// overflowing, broken or pure noise. A behavioral frame decoder predicts
// each result; results are compared field by field in order. Sender and
// receiver idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module ascii_can_frame_parser_tb;
   import ascp_pkg::*;

   typedef struct packed {
      bit                  valid_res;
      bit [ID_W-1:0]       frame_id;
      bit [BYTE_CNT_W-1:0] byte_count;
      bit [PAYLOAD_W-1:0]  payload;
      bit                  is_start;
      bit                  is_stop;
   } frame_result_type;

   class frame_scoreboard;
      bit                 in_payload;
      bit                 bad_frame;
      bit [ID_CNT_W-1:0]  id_cnt;
      bit [ID_W-1:0]      id_val;
      bit [4:0]           data_cnt;
      bit [PAYLOAD_W-1:0] data_val;
      frame_result_type   expected_frames[$];
      int                 errors;

      function void clear_frame();
         in_payload = 1'b0;
         bad_frame  = 1'b0;
         id_cnt     = '0;
         id_val     = '0;
         data_cnt   = '0;
         data_val   = '0;
      endfunction

      function int nibble_of(bit [7:0] ch);
         if (ch >= CHAR_0 && ch <= CHAR_9) return int'(ch - CHAR_0);
         if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) return ch - CHAR_LO_A + 10;
         if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) return ch - CHAR_UP_A + 10;
         return -1;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Advance the frame state by one character; queue a result on last.
      function void note_char(bit [7:0] ch, bit last);
         int               nib;
         int               pos;
         bit               ok;
         bit [7:0]         b0;
         bit [7:0]         b1;
         frame_result_type r;
         nib = nibble_of(ch);
         if (!in_payload) begin
            if (ch == CHAR_HASH) begin
               in_payload = 1'b1;
            end else if (nib < 0) begin
               bad_frame = 1'b1;
            end else if (id_cnt < ID_MAX_DIGITS) begin
               id_val = {id_val[ID_W-5:0], 4'(nib)};
               id_cnt++;
            end else begin
               id_cnt    = ID_OVERFLOW;
               bad_frame = 1'b1;
            end
         end else begin
            if (nib < 0) begin
               bad_frame = 1'b1;
            end else if (data_cnt < MAX_DIGITS) begin
               // high nibble of each byte first
               pos = (data_cnt >> 1) * 8 + (data_cnt[0] ? 0 : 4);
               data_val |= 64'(nib) << pos;
               data_cnt++;
            end else begin
               data_cnt  = 5'(MAX_DIGITS + 1);
               bad_frame = 1'b1;
            end
         end
         if (!last) return;
         ok = !bad_frame && in_payload && id_cnt >= 1 && id_cnt <= ID_MAX_DIGITS &&
              data_cnt >= 2 && data_cnt <= MAX_DIGITS && !data_cnt[0];
         r = '0;
         if (ok) begin
            b0           = data_val[7:0];
            b1           = data_val[15:8];
            r.valid_res  = 1'b1;
            r.frame_id   = id_val;
            r.byte_count = BYTE_CNT_W'(data_cnt >> 1);
            r.payload    = data_val;
            r.is_start   = id_val == CMD_ID && r.byte_count == CMD_BYTES &&
                           b1 == CMD_BYTE_ONE && (b0 == CMD_BYTE_RUN || b0 == CMD_BYTE_ALT);
            r.is_stop    = id_val == CMD_ID && r.byte_count == CMD_BYTES &&
                           b0 == CMD_BYTE_RUN && b1 == CMD_BYTE_ALT;
         end
         expected_frames.push_back(r);
         clear_frame();
      endfunction

      task check_frame(frame_result_type got);
         frame_result_type exp;
         if (expected_frames.size() == 0) begin
            report_mismatch("result item with no frame pending");
            return;
         end
         exp = expected_frames.pop_front();
         if (got.valid_res != exp.valid_res)
            report_mismatch($sformatf("valid_res %0d, expected %0d",
                                      got.valid_res, exp.valid_res));
         if (got.frame_id != exp.frame_id)
            report_mismatch($sformatf("frame_id %h, expected %h",
                                      got.frame_id, exp.frame_id));
         if (got.byte_count != exp.byte_count)
            report_mismatch($sformatf("byte_count %0d, expected %0d",
                                      got.byte_count, exp.byte_count));
         if (got.payload != exp.payload)
            report_mismatch($sformatf("payload %h, expected %h",
                                      got.payload, exp.payload));
         if (got.is_start != exp.is_start)
            report_mismatch($sformatf("is_start %0d, expected %0d",
                                      got.is_start, exp.is_start));
         if (got.is_stop != exp.is_stop)
            report_mismatch($sformatf("is_stop %0d, expected %0d",
                                      got.is_stop, exp.is_stop));
      endtask
   endclass

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_character = '0;
   logic                  req_last      = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic                  rsp_valid_res;
   logic [ID_W-1:0]       rsp_frame_id;
   logic [BYTE_CNT_W-1:0] rsp_byte_count;
   logic [PAYLOAD_W-1:0]  rsp_payload;
   logic                  rsp_is_start;
   logic                  rsp_is_stop;

   frame_scoreboard sb = new();
   bit [7:0]        frame_buf[$];
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_requests = 0;
   int              hold_served   = 0;
   int              hold_left     = 0;
   int              chars_sent    = 0;

   ascii_can_frame_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_frame_id   (rsp_frame_id),
      .rsp_byte_count (rsp_byte_count),
      .rsp_payload    (rsp_payload),
      .rsp_is_start   (rsp_is_start),
      .rsp_is_stop    (rsp_is_stop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_char(req_character, req_last);
         if (rsp_valid && !rsp_stall)
            sb.check_frame({rsp_valid_res, rsp_frame_id, rsp_byte_count,
                            rsp_payload, rsp_is_start, rsp_is_stop});
      end
   end

   function automatic bit [7:0] hex_char(bit [3:0] v);
      if (v < 10) return CHAR_0 + v;
      return 8'(($urandom_range(1) ? CHAR_LO_A : CHAR_UP_A) + v - 10);
   endfunction

   task automatic add_hex_digits(int n);
      repeat (n) frame_buf.push_back(hex_char(4'($urandom_range(15))));
   endtask

   task automatic add_byte(bit [7:0] b);
      frame_buf.push_back(hex_char(b[7:4]));
      frame_buf.push_back(hex_char(b[3:0]));
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
   endtask

   // Offer one item and hold it until the block takes it.
   task automatic send_char(bit [7:0] ch, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      req_last      <= last;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_char(frame_buf[i], i == frame_buf.size() - 1);
      frame_buf.delete();
   endtask

   task automatic build_random_frame();
      int       kind;
      int       nb;
      int       pos;
      bit [7:0] pick;
      kind = $urandom_range(99);
      if (kind < 60 || (kind >= 80 && kind < 90)) begin
         add_hex_digits($urandom_range(1, 3));
         frame_buf.push_back(CHAR_HASH);
         add_hex_digits(2 * ($urandom_range(3) == 0 ? $urandom_range(5, 8)
                                                    : $urandom_range(1, 4)));
         // corrupt one character: a stray separator or any byte at all
         if (kind >= 80) begin
            pos = $urandom_range(frame_buf.size() - 1);
            frame_buf[pos] = $urandom_range(1) ? CHAR_HASH : 8'($urandom_range(255));
         end
      end else if (kind < 72) begin
         case ($urandom_range(3))
            0: add_hex_digits(3);
            1: begin
               frame_buf.push_back(hex_char(CMD_ID[7:4]));
               frame_buf.push_back(hex_char(CMD_ID[3:0]));
            end
            default: begin
               frame_buf.push_back(hex_char(CMD_ID[11:8]));
               frame_buf.push_back(hex_char(CMD_ID[7:4]));
               frame_buf.push_back(hex_char(CMD_ID[3:0]));
            end
         endcase
         frame_buf.push_back(CHAR_HASH);
         nb = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 2;
         repeat (nb) begin
            case ($urandom_range(3))
               0: pick = CMD_BYTE_RUN;
               1: pick = CMD_BYTE_ALT;
               2: pick = CMD_BYTE_ONE;
               default: pick = 8'($urandom_range(255));
            endcase
            add_byte(pick);
         end
      end else if (kind < 80) begin
         case ($urandom_range(3))
            0: begin
               add_hex_digits($urandom_range(4, 6));
               frame_buf.push_back(CHAR_HASH);
               add_hex_digits(2 * $urandom_range(1, 2));
            end
            1: begin
               add_hex_digits($urandom_range(1, 3));
               frame_buf.push_back(CHAR_HASH);
               add_hex_digits($urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 4));
            end
            2: begin
               add_hex_digits($urandom_range(1, 3));
               frame_buf.push_back(CHAR_HASH);
               add_hex_digits(2 * $urandom_range(0, 7) + 1);
            end
            default: begin
               add_hex_digits($urandom_range(0, 3));
               frame_buf.push_back(CHAR_HASH);
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic run_random(int n_chars);
      int target;
      target = chars_sent + n_chars;
      while (chars_sent < target) begin
         build_random_frame();
         send_frame();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 67;
      foreach (frame_buf[i]) frame_buf.delete();
      add_text("0A0#6601"); send_frame();
      add_text("0a0#ff01"); send_frame();
      add_text("0A0#66FF"); send_frame();
      add_text("#");        send_frame();
      add_text("7");        send_frame();

      run_random(200);
      send_idle_pct = 67;
      recv_idle_pct = 11;
      run_random(200);

      // fill the block while the receiver holds off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      run_random(200);

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
